FILE: rtl/interpolated_joint_motion_time_macros.svh
// assertion macros for the interpolated joint motion time checker
// no dependencies; included by the checker file
`ifndef INTERPOLATED_JOINT_MOTION_TIME_MACROS_SVH
`define INTERPOLATED_JOINT_MOTION_TIME_MACROS_SVH

// same-cycle implication, disabled during reset
`define IJMT_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("ijmt check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define IJMT_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("ijmt check failed: next-cycle implication");

`endif

FILE: rtl/ijmt_pkg.sv
// shared types and constants for the interpolated joint motion time block
// no dependencies
`timescale 1ns / 1ps

package ijmt_pkg;

  localparam int TIME_W     = 25;
  localparam int ANGLE_W    = 16;
  localparam int DIST_W     = 16;
  localparam int STEP_W     = 15;
  localparam int ROWS_W     = 7;
  localparam int ROW_W      = 6;
  localparam int JOINT_W    = 3;
  localparam int QUO_W      = 25;
  localparam int PROD_W     = 41;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);
  localparam logic [ROWS_W-1:0] ROWS_RESET = '0;
  localparam int                TWO_PI_Q12 = 25736;

  localparam logic [CNT_W-1:0] DIV1_STEPS = CNT_W'(STEP_W);
  localparam logic [CNT_W-1:0] DIV2_STEPS = CNT_W'(QUO_W);

  localparam logic signed [TIME_W-1:0] TIME_NONE = '1;
  localparam logic signed [TIME_W-1:0] TIME_MAX  = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN  = {1'b1, {(TIME_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_TABLE,
    ST_RANGE,
    ST_COARSE
  } status_t;

  typedef enum logic {
    FN_WRITE,
    FN_QUERY
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE,
    CFG_ROWS_LOADED
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_ABS,
    S_CHECK,
    S_DIV1,
    S_IDX,
    S_RD1,
    S_MUL,
    S_ROUND,
    S_DIV2,
    S_SAT,
    S_ACCUM
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic absd;
    logic check;
    logic idx;
    logic rd1;
    logic mul;
    logic round;
    logic sat;
    logic accum;
  } cmd_t;

  typedef struct packed {
    logic early_fail;
    logic idx_fail;
    logic div_last;
  } stat_t;

endpackage

FILE: rtl/interpolated_joint_motion_time.sv
// top level: joint motion time estimate by table interpolation
// depends on ijmt_pkg, ijmt_ctrl, ijmt_dp (and ijmt_div below it)
`timescale 1ns / 1ps
//
// usage
// - config: cfg_we with cfg_index 0 (table step) or 1 (rows loaded) and cfg_wdata,
//   written at the clock edge, only while busy is low
// - input: an item transfers at an edge with start high and busy low; in_func 0
//   writes one table word, in_func 1 queries one joint, in_last ends a query
// - result: out_valid is high for one cycle with out_motion_time, out_status
//   and out_done_res, once per query, after the joint that carries in_last
// - a table write keeps busy high through its write state, then returns to idle
// - a query joint keeps busy high while it runs, including two passes through
//   the bit-serial divider: 15 steps for index and fraction, 25 steps for the
//   rounded interpolation quotient
// - a joint rejected before the divider (no table, bad joint, too far) skips
//   both divider passes, one rejected at the index check skips the second
// - out_valid rises as busy falls after the last joint is done; the next item
//   may transfer in that cycle
// - the receiver cannot stall; results are not held
// - synchronous reset: table step 256, rows loaded 0, running max and query
//   status cleared; table contents are kept and undefined until written
//
module interpolated_joint_motion_time #(
  parameter int MAX_ROWS   = 64,
  parameter int NUM_JOINTS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [ijmt_pkg::ROW_W-1:0]          in_row,
  input  logic [ijmt_pkg::JOINT_W-1:0]        in_joint,
  input  logic signed [ijmt_pkg::TIME_W-1:0]  in_table_time,
  input  logic signed [ijmt_pkg::ANGLE_W-1:0] in_start_angle,
  input  logic signed [ijmt_pkg::ANGLE_W-1:0] in_end_angle,
  input  logic                                in_last,
  input  logic                                cfg_we,
  input  logic [ijmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ijmt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  output logic signed [ijmt_pkg::TIME_W-1:0]  out_motion_time,
  output logic [1:0]                          out_status,
  output logic                                out_done_res
);
  import ijmt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ijmt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  ijmt_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .NUM_JOINTS (NUM_JOINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_row          (in_row),
    .in_joint        (in_joint),
    .in_table_time   (in_table_time),
    .in_start_angle  (in_start_angle),
    .in_end_angle    (in_end_angle),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_motion_time (out_motion_time),
    .out_status      (out_status),
    .out_done_res    (out_done_res)
  );

endmodule

FILE: rtl/ijmt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on ijmt_pkg
`timescale 1ns / 1ps

module ijmt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [ijmt_pkg::CNT_W-1:0]  n_steps,
  input  logic [ijmt_pkg::STEP_W-1:0] divisor,
  input  logic [ijmt_pkg::STEP_W-1:0] init_rem,
  input  logic [ijmt_pkg::QUO_W-1:0]  init_quo,
  output logic [ijmt_pkg::QUO_W-1:0]  quo,
  output logic [ijmt_pkg::STEP_W-1:0] rem,
  output logic                        last
);
  import ijmt_pkg::*;

  logic [CNT_W-1:0]  cnt_r;
  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W:0]   part;
  logic              ge;

  // partial remainder stays below the divisor, so the shifted value fits
  always_comb begin
    part    = {rem_r, quo_r[QUO_W-1]};
    ge      = part >= {1'b0, divisor};
    rem_nxt = ge ? STEP_W'(part - {1'b0, divisor}) : part[STEP_W-1:0];
    quo_nxt = {quo_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= n_steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= init_rem;
      quo_r <= init_quo;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign last = cnt_r == CNT_W'(1);

endmodule

FILE: rtl/ijmt_dp.sv
// datapath: config registers, time table memory, distance, divider, interpolation, max
// depends on ijmt_pkg and ijmt_div
`timescale 1ns / 1ps

module ijmt_dp #(
  parameter int MAX_ROWS   = 64,
  parameter int NUM_JOINTS = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ijmt_pkg::cmd_t                     cmd,
  output ijmt_pkg::stat_t                    stat,
  input  logic                               cfg_we,
  input  logic [ijmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ijmt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [ijmt_pkg::ROW_W-1:0]         in_row,
  input  logic [ijmt_pkg::JOINT_W-1:0]       in_joint,
  input  logic signed [ijmt_pkg::TIME_W-1:0] in_table_time,
  input  logic signed [ijmt_pkg::ANGLE_W-1:0] in_start_angle,
  input  logic signed [ijmt_pkg::ANGLE_W-1:0] in_end_angle,
  input  logic                               in_last,
  output logic                               out_valid,
  output logic signed [ijmt_pkg::TIME_W-1:0] out_motion_time,
  output logic [1:0]                         out_status,
  output logic                               out_done_res
);
  import ijmt_pkg::*;

  localparam int DEPTH = MAX_ROWS * NUM_JOINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(MAX_ROWS + 1);

  // config
  logic [STEP_W-1:0] step_r;
  logic [ROWS_W-1:0] rows_r;
  logic [STEP_W-1:0] step_eff;
  logic [RCW-1:0]    rows_eff;

  // captured item
  logic [ROW_W-1:0]          row_r;
  logic [JOINT_W-1:0]        joint_r;
  logic signed [TIME_W-1:0]  tt_r;
  logic signed [ANGLE_W-1:0] sa_r, ea_r;
  logic                      last_r;

  // working registers
  logic [DIST_W-1:0]         d_r;
  logic signed [TIME_W-1:0]  mem [DEPTH];
  logic signed [TIME_W-1:0]  mem_q;
  logic signed [TIME_W-1:0]  t0_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      neg_r;
  logic signed [TIME_W-1:0]  t_r;
  logic signed [TIME_W-1:0]  max_r, max_nxt;
  status_t                   jst_r, qst_r, qst_nxt, early;

  logic                      out_valid_r, out_done_res_r;
  logic signed [TIME_W-1:0]  out_time_r;
  status_t                   out_status_r;

  // combinational
  logic signed [ANGLE_W:0]   adiff;
  logic [DIST_W-1:0]         abs_dist;
  logic [STEP_W-1:0]         idx;
  logic                      idx_fail;
  logic                      wr_ok;
  logic [AW-1:0]             waddr, addr0, addr1, raddr;
  logic signed [TIME_W:0]    tdiff;
  logic signed [PROD_W:0]    prod_full;
  logic signed [PROD_W-1:0]  prod_abs;
  logic [PROD_W-2:0]         rnd;
  logic                      div_load;
  logic [STEP_W-1:0]         div_rem_in, div_rem;
  logic [QUO_W-1:0]          div_quo_in, div_quo;
  logic [CNT_W-1:0]          div_n;
  logic                      div_last;
  logic signed [TIME_W+1:0]  qs, sum;
  logic signed [TIME_W-1:0]  t_sat;
  logic                      add_ok;

  always_comb begin
    step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
    rows_eff = (32'(rows_r) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_r);

    adiff    = $signed({ea_r[ANGLE_W-1], ea_r}) - $signed({sa_r[ANGLE_W-1], sa_r});
    abs_dist = adiff[ANGLE_W] ? DIST_W'(-adiff) : DIST_W'(adiff);

    if (rows_eff == '0) begin
      early = ST_NO_TABLE;
    end else if (32'(joint_r) >= NUM_JOINTS) begin
      early = ST_RANGE;
    end else if ((17'(d_r) + 17'(step_eff)) > 17'(TWO_PI_Q12)) begin
      early = ST_RANGE;
    end else begin
      early = ST_OK;
    end

    idx      = div_quo[STEP_W-1:0];
    idx_fail = (16'(idx) + 16'd1) >= 16'(rows_eff);
    addr0    = AW'(32'(idx) * NUM_JOINTS + 32'(joint_r));
    addr1    = AW'(32'(idx) * NUM_JOINTS + NUM_JOINTS + 32'(joint_r));
    raddr    = cmd.rd1 ? addr1 : addr0;
    wr_ok    = (32'(row_r) < MAX_ROWS) && (32'(joint_r) < NUM_JOINTS);
    waddr    = AW'(32'(row_r) * NUM_JOINTS + 32'(joint_r));

    tdiff     = $signed({mem_q[TIME_W-1], mem_q}) - $signed({t0_r[TIME_W-1], t0_r});
    prod_full = $signed({1'b0, div_rem}) * tdiff;

    // magnitude plus half step, rounds ties away from zero
    prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;
    rnd      = prod_abs[PROD_W-2:0] + (PROD_W-1)'(step_eff >> 1);

    div_load   = (cmd.check && early == ST_OK) || cmd.round;
    div_n      = cmd.round ? DIV2_STEPS : DIV1_STEPS;
    div_rem_in = cmd.round ? rnd[PROD_W-2:QUO_W] : '0;
    div_quo_in = cmd.round ? rnd[QUO_W-1:0]
                           : {d_r[STEP_W-1:0], (QUO_W-STEP_W)'(0)};

    qs    = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    sum   = $signed({{2{t0_r[TIME_W-1]}}, t0_r}) + qs;
    if (sum[TIME_W+1:TIME_W-1] == '0 || sum[TIME_W+1:TIME_W-1] == '1) begin
      t_sat = sum[TIME_W-1:0];
    end else begin
      t_sat = sum[TIME_W+1] ? TIME_MIN : TIME_MAX;
    end

    add_ok  = (jst_r == ST_OK) || (jst_r == ST_COARSE);
    max_nxt = (add_ok && t_r > max_r) ? t_r : max_r;
    qst_nxt = (qst_r == ST_OK) ? jst_r : qst_r;
  end

  ijmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .n_steps  (div_n),
    .divisor  (step_eff),
    .init_rem (div_rem_in),
    .init_quo (div_quo_in),
    .quo      (div_quo),
    .rem      (div_rem),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_SIZE:   step_r <= cfg_wdata[STEP_W-1:0];
        CFG_ROWS_LOADED: rows_r <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r   <= in_row;
      joint_r <= in_joint;
      tt_r    <= in_table_time;
      sa_r    <= in_start_angle;
      ea_r    <= in_end_angle;
      last_r  <= in_last;
    end
    if (cmd.absd) begin
      d_r <= abs_dist;
    end
    if (cmd.rd1) begin
      t0_r <= mem_q;
    end
    if (cmd.mul) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
    if (cmd.round) begin
      neg_r <= prod_r[PROD_W-1];
    end
    if (cmd.sat) begin
      t_r <= t_sat;
    end
  end

  // table memory, one write port and one read port
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[waddr] <= tt_r;
    end
    if (cmd.idx || cmd.rd1) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jst_r       <= ST_OK;
      qst_r       <= ST_OK;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.accum && last_r;
      if (cmd.check) begin
        jst_r <= early;
      end else if (cmd.idx && idx_fail) begin
        jst_r <= ST_RANGE;
      end else if (cmd.mul && t0_r == TIME_NONE) begin
        jst_r <= ST_COARSE;
      end
      if (cmd.accum) begin
        if (last_r) begin
          max_r <= '0;
          qst_r <= ST_OK;
        end else begin
          max_r <= max_nxt;
          qst_r <= qst_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && last_r) begin
      out_time_r     <= (qst_nxt == ST_NO_TABLE || qst_nxt == ST_RANGE)
                        ? TIME_NONE : max_nxt;
      out_status_r   <= qst_nxt;
      out_done_res_r <= 1'b1;
    end
  end

  assign stat.early_fail = early != ST_OK;
  assign stat.idx_fail   = idx_fail;
  assign stat.div_last   = div_last;

  assign out_valid       = out_valid_r;
  assign out_motion_time = out_time_r;
  assign out_status      = out_status_r;
  assign out_done_res    = out_done_res_r;

endmodule

FILE: rtl/ijmt_ctrl.sv
// controller state machine sequencing writes and joint queries
// depends on ijmt_pkg
`timescale 1ns / 1ps

module ijmt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_func,
  input  ijmt_pkg::stat_t stat,
  output ijmt_pkg::cmd_t  cmd,
  output logic            busy
);
  import ijmt_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_func == FN_QUERY) ? S_ABS : S_WRITE;
        end
      end
      S_WRITE: state_nxt = S_IDLE;
      S_ABS:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = stat.early_fail ? S_ACCUM : S_DIV1;
      S_DIV1:  state_nxt = stat.div_last ? S_IDX : S_DIV1;
      S_IDX:   state_nxt = stat.idx_fail ? S_ACCUM : S_RD1;
      S_RD1:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_DIV2;
      S_DIV2:  state_nxt = stat.div_last ? S_SAT : S_DIV2;
      S_SAT:   state_nxt = S_ACCUM;
      S_ACCUM: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_WRITE: cmd.wr    = 1'b1;
      S_ABS:   cmd.absd  = 1'b1;
      S_CHECK: cmd.check = 1'b1;
      S_IDX:   cmd.idx   = 1'b1;
      S_RD1:   cmd.rd1   = 1'b1;
      S_MUL:   cmd.mul   = 1'b1;
      S_ROUND: cmd.round = 1'b1;
      S_SAT:   cmd.sat   = 1'b1;
      S_ACCUM: cmd.accum = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/ijmt_checker.sv
// port-level checks for the interpolated joint motion time block, with bind
// depends on ijmt_pkg and interpolated_joint_motion_time_macros.svh
`timescale 1ns / 1ps
`include "interpolated_joint_motion_time_macros.svh"

module ijmt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [ijmt_pkg::TIME_W-1:0] out_motion_time,
  input logic [1:0]                         out_status,
  input logic                               out_done_res
);
  import ijmt_pkg::*;

  `IJMT_ASSERT_IMP(a_done_flag, clk, rst_n, out_valid, out_done_res)
  `IJMT_ASSERT_IMP(a_fail_time, clk, rst_n, out_valid && (out_status == ST_NO_TABLE || out_status == ST_RANGE), out_motion_time == TIME_NONE)
  `IJMT_ASSERT_NXT(a_transfer_busy, clk, rst_n, start && !busy, busy)
  `IJMT_ASSERT_NXT(a_single_result, clk, rst_n, out_valid, !out_valid)
  `IJMT_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)

endmodule

bind interpolated_joint_motion_time ijmt_checker u_ijmt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_motion_time (out_motion_time),
  .out_status      (out_status),
  .out_done_res    (out_done_res)
);

FILE: test/interpolated_joint_motion_time_checker.sv
// checker for the interpolated joint motion time block: watches the config port and
// both channels, predicts each motion result and compares it field by field
// depends on ijmt_pkg
`timescale 1ns / 1ps

module interpolated_joint_motion_time_checker
  import ijmt_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int NUM_JOINTS = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_func,
  input  logic [ROW_W-1:0]           in_row,
  input  logic [JOINT_W-1:0]         in_joint,
  input  logic signed [TIME_W-1:0]   in_table_time,
  input  logic signed [ANGLE_W-1:0]  in_start_angle,
  input  logic signed [ANGLE_W-1:0]  in_end_angle,
  input  logic                       in_last,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       out_valid,
  input  logic signed [TIME_W-1:0]   out_motion_time,
  input  logic [1:0]                 out_status,
  input  logic                       out_done_res,
  output int                         fail_count,
  output int                         pending,
  output int                         results_seen
);

  typedef struct {
    logic signed [TIME_W-1:0] motion_time;
    status_t                  status;
  } motion_result_t;

  motion_result_t           motion_due[$];
  logic signed [TIME_W-1:0] time_words[MAX_ROWS*NUM_JOINTS];
  logic [STEP_W-1:0]        step_reg;
  logic [ROWS_W-1:0]        rows_reg;
  logic signed [TIME_W-1:0] peak_time;
  status_t                  held_status;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    foreach (time_words[i]) time_words[i] = '0;
  end

  task automatic report_mismatch(string what);
    $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  // time of one joint; status says whether it counts toward the maximum
  function automatic status_t joint_lookup(int delta, int jnt,
                                           output logic signed [TIME_W-1:0] t);
    int     rows_eff;
    int     step_eff;
    int     idx;
    int     frac;
    longint t0;
    longint t1;
    longint num;
    longint quo;
    longint sum;
    t = '0;
    rows_eff = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    step_eff = (step_reg == 0) ? 1 : int'(step_reg);
    if (rows_eff == 0) return ST_NO_TABLE;
    if (jnt >= NUM_JOINTS) return ST_RANGE;
    if (delta + step_eff > TWO_PI_Q12) return ST_RANGE;
    idx = delta / step_eff;
    if (idx + 1 >= rows_eff) return ST_RANGE;
    frac = delta - idx * step_eff;
    t0 = time_words[idx*NUM_JOINTS + jnt];
    t1 = time_words[(idx+1)*NUM_JOINTS + jnt];
    num = longint'(frac) * (t1 - t0);
    // round half away from zero
    if (num >= 0) quo = (num + step_eff/2) / step_eff;
    else quo = -((-num + step_eff/2) / step_eff);
    sum = t0 + quo;
    if (sum > longint'(TIME_MAX)) sum = longint'(TIME_MAX);
    if (sum < longint'(TIME_MIN)) sum = longint'(TIME_MIN);
    t = sum[TIME_W-1:0];
    return (t0 == -1) ? ST_COARSE : ST_OK;
  endfunction

  always @(posedge clk) begin : watch
    motion_result_t           want;
    logic signed [TIME_W-1:0] jt;
    status_t                  st;
    int                       delta;
    int                       sa;
    int                       ea;
    if (!rst_n) begin
      step_reg    = STEP_RESET;
      rows_reg    = ROWS_RESET;
      peak_time   = '0;
      held_status = ST_OK;
      motion_due.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (motion_due.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no query pending",
                                    out_motion_time, out_status));
        end else begin
          want = motion_due.pop_front();
          if (out_motion_time !== want.motion_time)
            report_mismatch($sformatf("motion_time got %0d want %0d",
                                      out_motion_time, want.motion_time));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_status, want.status));
          if (out_done_res !== 1'b1)
            report_mismatch($sformatf("done_res got %b", out_done_res));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_STEP_SIZE) step_reg = cfg_wdata[STEP_W-1:0];
        else if (cfg_index == CFG_ROWS_LOADED) rows_reg = cfg_wdata[ROWS_W-1:0];
      end
      if (start && !busy) begin
        if (in_func == FN_WRITE) begin
          if (in_row < MAX_ROWS && in_joint < NUM_JOINTS)
            time_words[in_row*NUM_JOINTS + in_joint] = in_table_time;
        end else begin
          sa = in_start_angle;
          ea = in_end_angle;
          delta = ea - sa;
          if (delta < 0) delta = -delta;
          st = joint_lookup(delta, in_joint, jt);
          if ((st == ST_OK || st == ST_COARSE) && jt > peak_time) peak_time = jt;
          if (held_status == ST_OK) held_status = st;
          if (in_last) begin
            want.motion_time = (held_status == ST_NO_TABLE || held_status == ST_RANGE)
                               ? TIME_NONE : peak_time;
            want.status = held_status;
            motion_due = {motion_due, want};
            peak_time   = '0;
            held_status = ST_OK;
          end
        end
      end
    end
    pending = motion_due.size();
  end

endmodule

FILE: test/interpolated_joint_motion_time_tb.sv
// testbench top for the interpolated joint motion time block: loads the table,
// drives directed and random joint queries over many step and row settings
// depends on ijmt_pkg, interpolated_joint_motion_time and the checker module
`timescale 1ns / 1ps

module interpolated_joint_motion_time_tb;
  import ijmt_pkg::*;

  localparam int MAX_ROWS      = 64;
  localparam int NUM_JOINTS    = 7;
  localparam int LOAD_ROWS     = 32;
  localparam int SETTLE_CYCLES = 60;
  localparam int TIME_TOP      = 16777215;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_func;
  logic [ROW_W-1:0]          in_row;
  logic [JOINT_W-1:0]        in_joint;
  logic signed [TIME_W-1:0]  in_table_time;
  logic signed [ANGLE_W-1:0] in_start_angle;
  logic signed [ANGLE_W-1:0] in_end_angle;
  logic                      in_last;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      out_valid;
  logic signed [TIME_W-1:0]  out_motion_time;
  logic [1:0]                out_status;
  logic                      out_done_res;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent;
  int settings_run;
  int gap_pct;
  int cur_step;
  int cur_rows;

  interpolated_joint_motion_time #(
    .MAX_ROWS(MAX_ROWS),
    .NUM_JOINTS(NUM_JOINTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_row(in_row),
    .in_joint(in_joint),
    .in_table_time(in_table_time),
    .in_start_angle(in_start_angle),
    .in_end_angle(in_end_angle),
    .in_last(in_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_motion_time(out_motion_time),
    .out_status(out_status),
    .out_done_res(out_done_res)
  );

  interpolated_joint_motion_time_checker #(
    .MAX_ROWS(MAX_ROWS),
    .NUM_JOINTS(NUM_JOINTS)
  ) motion_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_row(in_row),
    .in_joint(in_joint),
    .in_table_time(in_table_time),
    .in_start_angle(in_start_angle),
    .in_end_angle(in_end_angle),
    .in_last(in_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_motion_time(out_motion_time),
    .out_status(out_status),
    .out_done_res(out_done_res),
    .fail_count(fail_count),
    .pending(pending),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("status: fail");
    $finish;
  end

  function automatic int rand_angle();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_time();
    case ($urandom_range(0, 5))
      0: return -1;
      1: return TIME_TOP;
      2: return 0;
      default: return int'($urandom_range(0, TIME_TOP));
    endcase
  endfunction

  // largest distance that reaches two valid rows under the current setting
  function automatic int valid_span();
    int step_eff;
    int rows_eff;
    int by_angle;
    int by_rows;
    step_eff = (cur_step == 0) ? 1 : cur_step;
    rows_eff = (cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows;
    if (rows_eff < 2) return -1;
    by_angle = TWO_PI_Q12 - step_eff;
    by_rows = (rows_eff - 1) * step_eff - 1;
    return (by_angle < by_rows) ? by_angle : by_rows;
  endfunction

  function automatic int pick_distance();
    int span;
    int step_eff;
    int d;
    span = valid_span();
    step_eff = (cur_step == 0) ? 1 : cur_step;
    if (span < 0) return int'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0: d = 0;
      1: d = span;
      2: begin
        d = int'($urandom_range(0, span / step_eff)) * step_eff;
        if ($urandom_range(0, 1) && d + step_eff - 1 <= span) d = d + step_eff - 1;
      end
      3: d = int'($urandom_range(span + 1, 65535));
      default: d = int'($urandom_range(0, span));
    endcase
    return d;
  endfunction

  task automatic sender_gap();
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // one transfer on the input channel; returns on the falling edge after it
  task automatic send_item(func_t f, int row, int jnt, int tt, int sa, int ea, bit last);
    sender_gap();
    start          <= 1'b1;
    in_func        <= f;
    in_row         <= row[ROW_W-1:0];
    in_joint       <= jnt[JOINT_W-1:0];
    in_table_time  <= tt[TIME_W-1:0];
    in_start_angle <= sa[ANGLE_W-1:0];
    in_end_angle   <= ea[ANGLE_W-1:0];
    in_last        <= last;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!(f == FN_WRITE && jnt >= NUM_JOINTS)) items_sent++;
  endtask

  task automatic write_word(int row, int jnt, int tt);
    send_item(FN_WRITE, row, jnt, tt, rand_angle(), rand_angle(),
              1'($urandom_range(0, 1)));
  endtask

  task automatic query_angles(int jnt, int sa, int ea, bit last);
    send_item(FN_QUERY, $urandom_range(0, 63), jnt, rand_time(), sa, ea, last);
  endtask

  task automatic query_joint(int jnt, int delta, bit last);
    int sa;
    int ea;
    int tmp;
    if (delta > 65535) delta = 65535;
    sa = int'($urandom_range(0, 65535 - delta)) - 32768;
    ea = sa + delta;
    if ($urandom_range(0, 1)) begin
      tmp = sa;
      sa = ea;
      ea = tmp;
    end
    query_angles(jnt, sa, ea, last);
  endtask

  // a complete query over one or more joints, now and then a write in between
  task automatic run_query();
    int n;
    int jnt;
    n = $urandom_range(1, NUM_JOINTS);
    for (int k = 0; k < n; k++) begin
      jnt = ($urandom_range(0, 19) == 0) ? 7 : int'($urandom_range(0, NUM_JOINTS - 1));
      if ($urandom_range(0, 19) == 0)
        write_word($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, NUM_JOINTS - 1),
                   rand_time());
      query_joint(jnt, pick_distance(), k == n - 1);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(int step, int rows);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_SIZE;
    cfg_wdata <= step[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_ROWS_LOADED;
    // upper bits are not part of the row count
    cfg_wdata <= {8'($urandom_range(0, 255)), rows[ROWS_W-1:0]};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_step = step;
    cur_rows = rows;
    settings_run++;
  endtask

  // every setting keeps its table reads inside the loaded rows
  task automatic run_setting(int step, int rows, int n, int gap);
    int target;
    set_config(step, rows);
    gap_pct = gap;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: write_word($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, 7), rand_time());
        1: query_angles($urandom_range(0, 7), rand_angle(), rand_angle(),
                        1'($urandom_range(0, 1)));
        default: run_query();
      endcase
    end
    query_joint(0, 0, 1);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = FN_WRITE;
    in_row         = '0;
    in_joint       = '0;
    in_table_time  = '0;
    in_start_angle = '0;
    in_end_angle   = '0;
    in_last        = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_STEP_SIZE;
    cfg_wdata      = '0;
    items_sent     = 0;
    settings_run   = 0;
    gap_pct        = 0;
    cur_step       = 256;
    cur_rows       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no table loaded after reset
    query_joint(0, 100, 1);
    query_joint(3, 0, 0);
    query_joint(7, 0, 1);

    // load the lower rows so no query reads an unwritten entry
    for (int r = 0; r < LOAD_ROWS; r++)
      for (int j = 0; j < NUM_JOINTS; j++)
        write_word(r, j, rand_time());

    set_config(256, LOAD_ROWS);
    query_joint(0, 0, 1);
    query_angles(1, -32768, 32767, 1);
    query_joint(7, 100, 1);
    query_joint(2, (LOAD_ROWS - 1) * 256 - 1, 1);
    query_joint(2, (LOAD_ROWS - 1) * 256, 1);
    query_joint(3, TWO_PI_Q12 - 255, 1);
    // coarse entry still interpolated
    write_word(3, 2, -1);
    write_word(4, 2, 5000);
    query_joint(2, 800, 1);
    // falling times with a rounding tie
    write_word(5, 3, 10000);
    write_word(6, 3, 99);
    query_joint(3, 5*256 + 128, 1);
    // all joints, with a write landing mid query
    for (int j = 0; j < NUM_JOINTS; j++) begin
      query_joint(j, 300*j + 50, j == NUM_JOINTS - 1);
      if (j == 2) write_word(6, 5, 777);
    end
    // first failing status wins
    query_angles(4, -32768, 32767, 0);
    query_joint(2, 800, 1);
    query_joint(2, 800, 0);
    query_joint(7, 0, 1);
    write_word(10, 7, 123);

    run_setting(256, LOAD_ROWS, 25, 30);
    run_setting(1, LOAD_ROWS, 15, 0);
    run_setting(0, 20, 15, 50);
    run_setting(TWO_PI_Q12, 64, 15, 20);
    run_setting(32767, 64, 10, 30);
    run_setting(400, LOAD_ROWS, 25, 40);
    run_setting(1000, 30, 20, 10);
    run_setting(4095, 7, 15, 30);
    run_setting(100, 2, 15, 50);
    run_setting(12868, 3, 15, 20);
    run_setting(256, 1, 10, 30);
    run_setting(900, 127, 20, 30);
    run_setting(700, 0, 10, 20);
    run_setting(256, LOAD_ROWS, 35, 0);

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d items under %0d step/row settings", items_sent, settings_run);
    $display("checked %0d motion results, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
